// ----- hdl/psz_pkg.sv -----
`default_nettype none
package psz_pkg;

  localparam int ImageWidthDef  = 256;
  localparam int ImageHeightDef = 256;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int NumRegs  = 7;
  localparam int DistW    = 44;
  localparam int NumW     = 56;
  localparam int QuotW    = 14;

  localparam logic [CfgIdxW-1:0] RegR0C01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegR0C23 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegR1C01 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegR1C23 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegR2C01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegR2C23 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCamera = 3'd6;

  typedef struct packed {
    logic               action;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [15:0]        pixel_index;
  } item_in_t;

  typedef struct packed {
    logic               covered;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic signed [19:0] surf_x;
    logic signed [19:0] surf_y;
    logic signed [19:0] surf_z;
  } item_out_t;

  typedef struct packed {
    logic [23:0]      colour;
    logic [59:0]      point;
    logic [DistW-1:0] range_sq;
  } pixel_t;

endpackage
`default_nettype wire

// ----- hdl/point_splat_zbuffer.sv -----
// A read runs S_RREAD then S_RDONE, which registers done; a splat is busy for projection
// and two 57-step divisions, or leaves at S_DIVSET if dropped for depth or facing.
// Throughput: one transaction at a time; busy is high from acceptance to end.
// Reset: synchronous; clears state, done and the config registers, then sweeps
// the occupancy memory, one pixel per cycle with busy high.
// The receiver cannot stall: a result is shown for one cycle with done high.
`default_nettype none
module point_splat_zbuffer
  import psz_pkg::*;
#(
  parameter int IMAGE_WIDTH  = ImageWidthDef,
  parameter int IMAGE_HEIGHT = ImageHeightDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire item_in_t            item,
  output      logic                done,
  output      item_out_t           result,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  localparam int Pixels = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AddrW  = $clog2(Pixels);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_RREAD  = 12'b000000000100,
    S_RDONE  = 12'b000000001000,
    S_MUL    = 12'b000000010000,
    S_SUM    = 12'b000000100000,
    S_DIVSET = 12'b000001000000,
    S_DIV    = 12'b000010000000,
    S_CHECK  = 12'b000100000000,
    S_SREAD  = 12'b001000000000,
    S_SCMP   = 12'b010000000000,
    S_DOT    = 12'b100000000000
  } state_t;

  state_t state;
  logic [CfgDataW-1:0] regs [NumRegs];
  item_in_t cur;
  logic [AddrW-1:0] addr;
  logic [AddrW:0] clr_cnt;

  // Projection products, one multiplier per point coefficient (the translation term is shifted), registered.
  logic signed [51:0] prod [12];
  logic signed [55:0] uvw [3];
  logic signed [41:0] dprod [3];
  logic signed [43:0] sq [3];
  logic signed [21:0] d [3];
  logic [DistW-1:0] range_sq;
  logic signed [43:0] dot;

  // Shared restoring divider for column then row.
  logic [NumW:0] rem;
  logic [NumW:0] dvd;
  logic [NumW:0] den2;
  logic [QuotW-1:0] quo;
  logic [5:0] dcnt;
  logic which;
  logic signed [55:0] num_sel;
  logic neg;
  logic [QuotW-1:0] col;
  logic [QuotW-1:0] row;
  logic col_neg;
  logic row_neg;
  logic rd_in_range;

  logic occ_we;
  logic occ_wd;
  logic occ_rd;
  logic [AddrW-1:0] occ_waddr;
  logic dat_we;
  pixel_t dat_wd;
  pixel_t dat_rd;

  function automatic logic signed [31:0] coefv(logic [63:0] r, logic hi);
    return hi ? r[63:32] : r[31:0];
  endfunction

  psz_ram #(.Width(1), .Depth(Pixels)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wd),
    .raddr(addr), .rdata(occ_rd)
  );

  psz_ram #(.Width($bits(pixel_t)), .Depth(Pixels)) u_dat (
    .clk(clk), .we(dat_we), .waddr(addr), .wdata(dat_wd),
    .raddr(addr), .rdata(dat_rd)
  );

  assign busy = (state != S_IDLE);
  assign occ_waddr = (state == S_CLEAR) ? clr_cnt[AddrW-1:0] : addr;
  assign num_sel = which ? uvw[1] : uvw[0];
  assign rd_in_range = {16'd0, cur.pixel_index} < 32'(Pixels);

  always_comb begin
    occ_we = 1'b0;
    occ_wd = 1'b0;
    dat_we = 1'b0;
    dat_wd.colour = {cur.red_in, cur.green_in, cur.blue_in};
    dat_wd.point = {cur.point_x, cur.point_y, cur.point_z};
    dat_wd.range_sq = range_sq;
    unique case (state)
      S_CLEAR: occ_we = 1'b1;
      S_RDONE: occ_we = occ_rd && rd_in_range;
      S_SCMP: begin
        if (!occ_rd || range_sq < dat_rd.range_sq) begin
          occ_we = 1'b1;
          occ_wd = 1'b1;
          dat_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      done <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        regs[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we && cfg_index < CfgIdxW'(NumRegs)) begin
        regs[cfg_index] <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AddrW+1)'(Pixels - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur <= item;
            addr <= AddrW'(item.pixel_index);
            state <= item.action ? S_RREAD : S_MUL;
          end
        end
        S_RREAD: state <= S_RDONE;
        S_RDONE: begin
          done <= 1'b1;
          if (rd_in_range && occ_rd) begin
            result <= {1'b1, dat_rd.colour, dat_rd.point};
          end else begin
            result <= '0;
          end
          state <= S_IDLE;
        end
        S_MUL: begin
          for (int r = 0; r < 3; r++) begin
            prod[4*r]   <= coefv(regs[2*r], 1'b0) * cur.point_x;
            prod[4*r+1] <= coefv(regs[2*r], 1'b1) * cur.point_y;
            prod[4*r+2] <= coefv(regs[2*r+1], 1'b0) * cur.point_z;
            prod[4*r+3] <= 52'(coefv(regs[2*r+1], 1'b1)) <<< 10;
          end
          d[0] <= 22'(cur.point_x) - 22'($signed(regs[RegCamera][20:0]));
          d[1] <= 22'(cur.point_y) - 22'($signed(regs[RegCamera][41:21]));
          d[2] <= 22'(cur.point_z) - 22'($signed(regs[RegCamera][62:42]));
          state <= S_DOT;
        end
        S_DOT: begin
          dprod[0] <= d[0] * cur.norm_x;
          dprod[1] <= d[1] * cur.norm_y;
          dprod[2] <= d[2] * cur.norm_z;
          for (int i = 0; i < 3; i++) begin
            sq[i] <= d[i] * d[i];
          end
          state <= S_SUM;
        end
        S_SUM: begin
          for (int r = 0; r < 3; r++) begin
            uvw[r] <= 56'(prod[4*r]) + 56'(prod[4*r+1]) + 56'(prod[4*r+2])
                      + 56'(prod[4*r+3]);
          end
          dot <= 44'(dprod[0]) + 44'(dprod[1]) + 44'(dprod[2]);
          range_sq <= DistW'(sq[0]) + DistW'(sq[1]) + DistW'(sq[2]);
          which <= 1'b0;
          state <= S_DIVSET;
        end
        S_DIVSET: begin
          if (uvw[2] <= 0 || dot > 0) begin
            state <= S_IDLE;
          end else begin
            neg <= num_sel[NumW-1];
            dvd <= {num_sel[NumW-1] ? -num_sel : num_sel, 1'b0}
                   + {1'b0, uvw[2]};
            den2 <= {uvw[2], 1'b0};
            rem <= '0;
            quo <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Quotients of an in-range pixel fit QuotW bits; larger saturate below.
          if (dcnt == 6'(NumW + 1)) begin
            if (!which) begin
              col <= quo;
              col_neg <= neg && (quo != 0);
              which <= 1'b1;
              state <= S_DIVSET;
            end else begin
              row <= quo;
              row_neg <= neg && (quo != 0);
              state <= S_CHECK;
            end
          end else begin
            if ({rem[NumW-1:0], dvd[NumW]} >= den2) begin
              rem <= {rem[NumW-1:0], dvd[NumW]} - den2;
              quo <= (quo[QuotW-1] || quo == '1) ? '1 : {quo[QuotW-2:0], 1'b1};
            end else begin
              rem <= {rem[NumW-1:0], dvd[NumW]};
              quo <= quo[QuotW-1] ? '1 : {quo[QuotW-2:0], 1'b0};
            end
            dvd <= {dvd[NumW-1:0], 1'b0};
            dcnt <= dcnt + 1'b1;
          end
        end
        S_CHECK: begin
          if (col_neg || row_neg || col >= QuotW'(IMAGE_WIDTH)
              || row >= QuotW'(IMAGE_HEIGHT)) begin
            state <= S_IDLE;
          end else begin
            addr <= AddrW'(col) + AddrW'(IMAGE_WIDTH) * AddrW'(row);
            state <= S_SREAD;
          end
        end
        S_SREAD: state <= S_SCMP;
        S_SCMP: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/psz_ram.sv -----
`default_nettype none
module psz_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/psz_checker.sv -----
`default_nettype none
module psz_checker
  import psz_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire item_in_t  item,
  input wire logic      done,
  input wire item_out_t result
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action |-> ##3 done) else $error("read result late");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without transaction");
  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.covered |-> result.red_out == 0 && result.surf_x == 0)
    else $error("uncovered result not zero");
endmodule

bind point_splat_zbuffer psz_checker u_psz_checker (.*);
`default_nettype wire
